[sv/igr_pkg.sv]
// Shared types, constants and rounding helpers for the gravity removal and
// world rotation pipeline. No dependencies.
package igr_pkg;

   localparam int NUM_STAGES = 6;
   localparam int PROD_W     = 32;
   localparam int TERM_W     = 34;
   localparam int SCALE_W    = TERM_W + 17;
   localparam int ROT_W      = TERM_W + 16;
   localparam int SUM_W      = ROT_W + 2;
   localparam int Q28_SHIFT  = 28;
   localparam int Q14_SHIFT  = 14;
   localparam int S16_MAX    = 32767;
   localparam int S16_MIN    = -32768;

   localparam logic [15:0] LSB_PER_G_RESET = 16'd8192;
   localparam logic [SUM_W-1:0] Q28_BIAS = (SUM_W'(1) << Q28_SHIFT) - SUM_W'(1);
   localparam logic [TERM_W-1:0] Q14_BIAS = (TERM_W'(1) << Q14_SHIFT) - TERM_W'(1);

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [TERM_W-1:0] term_type;
   typedef term_type matrix_type [3][3];

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_data_type;

   typedef struct packed {
      logic signed [15:0] gravity_x;
      logic signed [15:0] gravity_y;
      logic signed [15:0] gravity_z;
      logic signed [15:0] linear_x;
      logic signed [15:0] linear_y;
      logic signed [15:0] linear_z;
      logic signed [15:0] world_x;
      logic signed [15:0] world_y;
      logic signed [15:0] world_z;
   } rsp_data_type;

   typedef struct packed {
      logic en_a;
      logic en_b;
   } stage_ctl_type;

   // Q28 -> integer, truncate toward zero, saturate to 16 bits
   function automatic logic signed [15:0] sat_q28(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] bias;
      logic signed [SUM_W-1:0] q;
      bias = v[SUM_W-1] ? signed'(Q28_BIAS) : '0;
      q = (v + bias) >>> Q28_SHIFT;
      if (q > SUM_W'(S16_MAX)) begin
         return 16'sh7fff;
      end else if (q < SUM_W'(S16_MIN)) begin
         return 16'sh8000;
      end
      return q[15:0];
   endfunction

   // Q28 -> Q14, truncate toward zero, saturate to 16 bits
   function automatic logic signed [15:0] sat_q14(input term_type v);
      term_type bias;
      term_type q;
      bias = v[TERM_W-1] ? signed'(Q14_BIAS) : '0;
      q = (v + bias) >>> Q14_SHIFT;
      if (q > TERM_W'(S16_MAX)) begin
         return 16'sh7fff;
      end else if (q < TERM_W'(S16_MIN)) begin
         return 16'sh8000;
      end
      return q[15:0];
   endfunction

   function automatic logic signed [15:0] sat_diff(input logic signed [16:0] v);
      if (v > 17'(S16_MAX)) begin
         return 16'sh7fff;
      end else if (v < 17'(S16_MIN)) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

endpackage

[sv/igr_quat_matrix.sv]
// Two pipeline stages that turn a Q2.14 quaternion into the Q28 rotation
// matrix: pairwise products, then the term sums. Uses igr_pkg.
module igr_quat_matrix (
   input  logic                      clock,
   input  igr_pkg::stage_ctl_type    ctl,
   input  logic signed [15:0]        quat_w,
   input  logic signed [15:0]        quat_x,
   input  logic signed [15:0]        quat_y,
   input  logic signed [15:0]        quat_z,
   output igr_pkg::matrix_type       mat
);

   igr_pkg::prod_type ww_ff, xx_ff, yy_ff, zz_ff;
   igr_pkg::prod_type wx_ff, wy_ff, wz_ff, xy_ff, xz_ff, yz_ff;
   igr_pkg::matrix_type mat_ff;
   igr_pkg::matrix_type mat_in;

   always_ff @(posedge clock) begin
      if (ctl.en_a) begin
         ww_ff <= quat_w * quat_w;
         xx_ff <= quat_x * quat_x;
         yy_ff <= quat_y * quat_y;
         zz_ff <= quat_z * quat_z;
         wx_ff <= quat_w * quat_x;
         wy_ff <= quat_w * quat_y;
         wz_ff <= quat_w * quat_z;
         xy_ff <= quat_x * quat_y;
         xz_ff <= quat_x * quat_z;
         yz_ff <= quat_y * quat_z;
      end
   end

   always_comb begin
      mat_in[0][0] = igr_pkg::term_type'(ww_ff) + igr_pkg::term_type'(xx_ff)
                   - igr_pkg::term_type'(yy_ff) - igr_pkg::term_type'(zz_ff);
      mat_in[0][1] = (igr_pkg::term_type'(xy_ff) - igr_pkg::term_type'(wz_ff)) <<< 1;
      mat_in[0][2] = (igr_pkg::term_type'(xz_ff) + igr_pkg::term_type'(wy_ff)) <<< 1;
      mat_in[1][0] = (igr_pkg::term_type'(xy_ff) + igr_pkg::term_type'(wz_ff)) <<< 1;
      mat_in[1][1] = igr_pkg::term_type'(ww_ff) - igr_pkg::term_type'(xx_ff)
                   + igr_pkg::term_type'(yy_ff) - igr_pkg::term_type'(zz_ff);
      mat_in[1][2] = (igr_pkg::term_type'(yz_ff) - igr_pkg::term_type'(wx_ff)) <<< 1;
      mat_in[2][0] = (igr_pkg::term_type'(xz_ff) - igr_pkg::term_type'(wy_ff)) <<< 1;
      mat_in[2][1] = (igr_pkg::term_type'(yz_ff) + igr_pkg::term_type'(wx_ff)) <<< 1;
      mat_in[2][2] = igr_pkg::term_type'(ww_ff) - igr_pkg::term_type'(xx_ff)
                   - igr_pkg::term_type'(yy_ff) + igr_pkg::term_type'(zz_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.en_b) begin
         mat_ff <= mat_in;
      end
   end

   assign mat = mat_ff;

endmodule

[sv/imu_gravity_removal_world_rotation.sv]
// Top level: gravity removal and world-frame rotation pipeline.
// Depends on igr_pkg and igr_quat_matrix.
//
// Usage:
//   req_*  : one beat = quaternion (Q2.14) plus raw accelerometer sample,
//            taken when req_valid is high and req_stall is low.
//   rsp_*  : one beat per request = gravity (Q2.14), linear acceleration and
//            world-frame acceleration, taken when rsp_valid is high and
//            rsp_stall is low.
//   csr_*  : writes accel_lsb_per_g; csr_ready is always high. Write only
//            while no beat is in flight.
// One beat enters per cycle while req_stall is low. Stages: products,
// matrix sums, gravity scale multiply, linear subtract, rotation
// multiplies, row sums with output register.
// Each stage holds its beat only while the stage after it is full and held,
// so empty slots close up; req_stall rises only when all 6 slots are full
// and the response is stalled.
// Reset (synchronous) empties the pipeline and sets accel_lsb_per_g to 8192.
module imu_gravity_removal_world_rotation (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  igr_pkg::req_data_type   req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output igr_pkg::rsp_data_type   rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [15:0]             csr_data
);

   localparam int NS = igr_pkg::NUM_STAGES;

   logic [15:0]   lsb_ff;
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] stage_en;

   igr_pkg::stage_ctl_type mat_ctl;
   igr_pkg::matrix_type    mat_b;

   logic signed [15:0] accel_a_ff [3];
   logic signed [15:0] accel_b_ff [3];
   logic signed [15:0] accel_c_ff [3];

   logic signed [igr_pkg::SCALE_W-1:0] scaled_c_ff [3];
   logic signed [15:0]                 grav_c_ff [3];
   logic signed [15:0]                 grav_d_ff [3];
   logic signed [15:0]                 grav_e_ff [3];
   igr_pkg::matrix_type                mat_c_ff;
   igr_pkg::matrix_type                mat_d_ff;

   logic signed [15:0]                 lin_in [3];
   logic signed [15:0]                 lin_d_ff [3];
   logic signed [15:0]                 lin_e_ff [3];
   logic signed [igr_pkg::ROT_W-1:0]   rot_e_ff [3][3];

   igr_pkg::rsp_data_type rsp_data_ff;
   igr_pkg::rsp_data_type rsp_data_in;

   logic signed [16:0] lsb_signed;

   // config register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lsb_ff <= igr_pkg::LSB_PER_G_RESET;
      end else if (csr_valid && csr_ready) begin
         lsb_ff <= csr_data;
      end
   end

   assign lsb_signed = signed'({1'b0, lsb_ff});

   // stage control
   always_comb begin
      stage_en[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[NS-1];
   assign rsp_data  = rsp_data_ff;

   // stages A and B
   assign mat_ctl.en_a = stage_en[0];
   assign mat_ctl.en_b = stage_en[1];

   igr_quat_matrix u_quat_matrix (
      .clock  (clock),
      .ctl    (mat_ctl),
      .quat_w (req_data.quat_w),
      .quat_x (req_data.quat_x),
      .quat_y (req_data.quat_y),
      .quat_z (req_data.quat_z),
      .mat    (mat_b)
   );

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         accel_a_ff[0] <= req_data.accel_x;
         accel_a_ff[1] <= req_data.accel_y;
         accel_a_ff[2] <= req_data.accel_z;
      end
      if (stage_en[1]) begin
         accel_b_ff <= accel_a_ff;
      end
   end

   // stage C: gravity row of the matrix times the scale
   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         for (int i = 0; i < 3; i++) begin
            scaled_c_ff[i] <= mat_b[2][i] * lsb_signed;
            grav_c_ff[i]   <= igr_pkg::sat_q14(mat_b[2][i]);
         end
         accel_c_ff <= accel_b_ff;
         mat_c_ff   <= mat_b;
      end
   end

   // stage D: linear acceleration
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lin_in[i] = igr_pkg::sat_diff(17'(accel_c_ff[i])
                   - 17'(igr_pkg::sat_q28(igr_pkg::SUM_W'(scaled_c_ff[i]))));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         lin_d_ff  <= lin_in;
         grav_d_ff <= grav_c_ff;
         mat_d_ff  <= mat_c_ff;
      end
   end

   // stage E: rotation products
   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               rot_e_ff[i][j] <= mat_d_ff[i][j] * lin_d_ff[j];
            end
         end
         lin_e_ff  <= lin_d_ff;
         grav_e_ff <= grav_d_ff;
      end
   end

   // stage F: row sums and output register
   always_comb begin
      rsp_data_in.gravity_x = grav_e_ff[0];
      rsp_data_in.gravity_y = grav_e_ff[1];
      rsp_data_in.gravity_z = grav_e_ff[2];
      rsp_data_in.linear_x  = lin_e_ff[0];
      rsp_data_in.linear_y  = lin_e_ff[1];
      rsp_data_in.linear_z  = lin_e_ff[2];
      rsp_data_in.world_x   = igr_pkg::sat_q28(igr_pkg::SUM_W'(rot_e_ff[0][0])
                            + igr_pkg::SUM_W'(rot_e_ff[0][1])
                            + igr_pkg::SUM_W'(rot_e_ff[0][2]));
      rsp_data_in.world_y   = igr_pkg::sat_q28(igr_pkg::SUM_W'(rot_e_ff[1][0])
                            + igr_pkg::SUM_W'(rot_e_ff[1][1])
                            + igr_pkg::SUM_W'(rot_e_ff[1][2]));
      rsp_data_in.world_z   = igr_pkg::sat_q28(igr_pkg::SUM_W'(rot_e_ff[2][0])
                            + igr_pkg::SUM_W'(rot_e_ff[2][1])
                            + igr_pkg::SUM_W'(rot_e_ff[2][2]));
   end

   always_ff @(posedge clock) begin
      if (stage_en[NS-1]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a held stage keeps its beat
   a_hold_keeps_beat: assert property (@(posedge clock) disable iff (reset)
      ((valid_ff & ~stage_en) != '0)
      |=> ((valid_ff & $past(valid_ff & ~stage_en)) == $past(valid_ff & ~stage_en)))
      else $error("held pipeline beat dropped");

   // input stalls only with every slot full
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("req_stall with an empty slot");

   // free output lets the whole pipe move
   a_free_out_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("req_stall without rsp_stall");

   // response count follows the valid chain
   a_out_follows_pipe: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NS-2] && stage_en[NS-1]) |=> rsp_valid)
      else $error("beat lost at output stage");

endmodule
